// ===== sv/clcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD number formatter: shared definitions
// Field widths, request codes, sequencer states, the job handed from the
// request decoder to the sequencer and the small character tables.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int FUNC_W    = 3;
   localparam int LINE_W    = 2;
   localparam int COLUMN_W  = 6;
   localparam int VALUE_W   = 17;
   localparam int COUNT_W   = 6;
   localparam int BYTE_W    = 8;
   localparam int BCD_DIGITS = 5;
   localparam int DIG_W     = 4 * BCD_DIGITS;
   localparam int MAX_CLEAR_DEFAULT = 40;

   // Request codes
   localparam logic [FUNC_W-1:0] FUNC_CHAR  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEC_S = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEC_U = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_BIN   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_HEX   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_INIT  = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_NONE  = 3'd7;

   localparam logic [BYTE_W-1:0] BASE_LINE1 = 8'h80;
   localparam logic [BYTE_W-1:0] BASE_LINE2 = 8'hC0;
   localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_ONE     = 8'h31;
   localparam logic [BYTE_W-1:0] BIN_SAT    = 8'd255;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_CURSOR,
      ST_CHAR,
      ST_LABEL,
      ST_SIGN,
      ST_WAIT,
      ST_SKIP,
      ST_DIGIT,
      ST_BITS,
      ST_SPACE
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [BYTE_W-1:0]  cursor;
      logic [BYTE_W-1:0]  chr;
      logic               neg;
      logic [DIG_W-1:0]   dig;
      logic [COUNT_W-1:0] cnt;
   } job_type;

   typedef struct packed {
      logic             done;
      logic [DIG_W-1:0] digits;
   } bcd_result_type;

   function automatic logic [BYTE_W-1:0] init_cmd(input logic [1:0] idx);
      logic [BYTE_W-1:0] c;
      unique case (idx)
         2'd0: c = 8'h38;
         2'd1: c = 8'h0C;
         2'd2: c = 8'h06;
         2'd3: c = 8'h01;
      endcase
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

   // Labels "Dec: ", "Bin: " and "Hex: " share their last two characters.
   function automatic logic [BYTE_W-1:0] label_byte(input logic [FUNC_W-1:0] func,
                                                    input logic [2:0] idx);
      logic [BYTE_W-1:0] c;
      unique case (idx)
         3'd0: c = (func == FUNC_BIN) ? 8'h42 : (func == FUNC_HEX) ? 8'h48 : 8'h44;
         3'd1: c = (func == FUNC_BIN) ? 8'h69 : 8'h65;
         3'd2: c = (func == FUNC_BIN) ? 8'h6E : (func == FUNC_HEX) ? 8'h78 : 8'h63;
         3'd3: c = 8'h3A;
         default: c = CH_SPACE;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/clcd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD number formatter: channel interfaces
// Request channel and LCD write channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface clcd_req_if;
   import clcd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic [LINE_W-1:0]          line;
   logic [COLUMN_W-1:0]        column;
   logic signed [VALUE_W-1:0]  value;
   logic [COUNT_W-1:0]         count;

   modport source (output valid, func, line, column, value, count, input ready);
   modport sink   (input valid, func, line, column, value, count, output ready);
endinterface

interface clcd_rsp_if;
   import clcd_pkg::*;
   logic              valid;
   logic              ready;
   logic              is_data;
   logic [BYTE_W-1:0] bus_byte;
   logic              last;

   modport source (output valid, is_data, bus_byte, last, input ready);
   modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface
`default_nettype wire

// ===== sv/clcd_bcd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shift-and-add-three conversion, one magnitude bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module clcd_bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [clcd_pkg::VALUE_W-1:0]  mag,
   output clcd_pkg::bcd_result_type      res
);
   import clcd_pkg::*;

   localparam int STEP_W = $clog2(VALUE_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0]  sh_ff, sh_in;
   logic [DIG_W-1:0]    bcd_ff, bcd_in;
   logic [DIG_W-1:0]    adj;

   // Each digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                   : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      sh_in   = sh_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = STEP_W'(VALUE_W);
         sh_in   = mag;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in  = {adj[DIG_W-2:0], sh_ff[VALUE_W-1]};
         sh_in   = {sh_ff[VALUE_W-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
   end

   assign res.done   = done_ff;
   assign res.digits = bcd_ff;

endmodule
`default_nettype wire

// ===== sv/clcd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD write sequencer
// Walks a request through init, cursor, character, label, sign, digit,
// bit and space phases, shifting digits out of one register a nibble or a
// bit at a time into the output word register.
// ----------------------------------------------------------------------------
module clcd_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_start,
   input  clcd_pkg::job_type         job,
   input  clcd_pkg::bcd_result_type  bcd,
   output logic                      idle,
   clcd_rsp_if.source                rsp_ch
);
   import clcd_pkg::*;

   state_type           state_ff, state_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [2:0]          idx_ff, idx_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIG_W-1:0]    dig_ff, dig_in;
   logic [BYTE_W-1:0]   cursor_ff, cursor_in;
   logic [BYTE_W-1:0]   chr_ff, chr_in;
   logic                neg_ff, neg_in;

   logic                out_valid_ff, out_valid_in;
   logic                out_rs_ff, out_rs_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;

   logic                emit_valid, emit_rs, emit_last, emit;
   logic [BYTE_W-1:0]   emit_byte;
   logic                slot_free;
   logic [3:0]          top_nib;
   logic [COUNT_W-1:0]  min_digits;
   logic                skip_zero;

   assign slot_free  = !out_valid_ff || rsp_ch.ready;
   assign top_nib    = dig_ff[DIG_W-1 -: 4];
   assign min_digits = (func_ff == FUNC_HEX) ? COUNT_W'(2) : COUNT_W'(1);
   assign skip_zero  = (top_nib == 4'd0) && (cnt_ff > min_digits);
   assign emit       = emit_valid && slot_free;
   assign idle       = (state_ff == ST_IDLE);

   // Word offered in each state
   always_comb begin
      emit_valid = 1'b0;
      emit_rs    = 1'b1;
      emit_byte  = CH_SPACE;
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE, ST_WAIT, ST_SKIP: begin
            emit_valid = 1'b0;
         end
         ST_INIT: begin
            emit_valid = 1'b1;
            emit_rs    = 1'b0;
            emit_byte  = init_cmd(idx_ff[1:0]);
            emit_last  = (idx_ff == 3'd3);
         end
         ST_CURSOR: begin
            emit_valid = 1'b1;
            emit_rs    = 1'b0;
            emit_byte  = cursor_ff;
            emit_last  = (func_ff == FUNC_CLEAR) && (cnt_ff == '0);
         end
         ST_CHAR: begin
            emit_valid = 1'b1;
            emit_byte  = chr_ff;
            emit_last  = 1'b1;
         end
         ST_LABEL: begin
            emit_valid = 1'b1;
            emit_byte  = label_byte(func_ff, idx_ff);
         end
         ST_SIGN: begin
            emit_valid = 1'b1;
            emit_byte  = CH_MINUS;
         end
         ST_DIGIT: begin
            emit_valid = 1'b1;
            emit_byte  = hex_char(top_nib);
            emit_last  = (cnt_ff == COUNT_W'(1));
         end
         ST_BITS: begin
            emit_valid = 1'b1;
            emit_byte  = dig_ff[DIG_W-1] ? CH_ONE : CH_ZERO;
            emit_last  = (cnt_ff == COUNT_W'(1));
         end
         ST_SPACE: begin
            emit_valid = 1'b1;
            emit_byte  = CH_SPACE;
            emit_last  = (cnt_ff == COUNT_W'(1));
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_start) begin
               state_in = (job.func == FUNC_INIT) ? ST_INIT : ST_CURSOR;
            end
         end
         ST_INIT: begin
            if (emit && idx_ff == 3'd3) state_in = ST_IDLE;
         end
         ST_CURSOR: begin
            if (emit) begin
               priority if (func_ff == FUNC_CHAR) begin
                  state_in = ST_CHAR;
               end else if (func_ff == FUNC_DEC_U) begin
                  state_in = ST_WAIT;
               end else if (func_ff == FUNC_CLEAR) begin
                  state_in = (cnt_ff == '0) ? ST_IDLE : ST_SPACE;
               end else begin
                  state_in = ST_LABEL;
               end
            end
         end
         ST_CHAR: begin
            if (emit) state_in = ST_IDLE;
         end
         ST_LABEL: begin
            if (emit && idx_ff == 3'd4) begin
               priority if (func_ff == FUNC_DEC_S) begin
                  state_in = neg_ff ? ST_SIGN : ST_WAIT;
               end else if (func_ff == FUNC_BIN) begin
                  state_in = ST_BITS;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SIGN: begin
            if (emit) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (bcd.done) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_zero) state_in = ST_DIGIT;
         end
         ST_DIGIT, ST_BITS, ST_SPACE: begin
            if (emit && cnt_ff == COUNT_W'(1)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath registers
   always_comb begin
      func_in   = func_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      dig_in    = dig_ff;
      cursor_in = cursor_ff;
      chr_in    = chr_ff;
      neg_in    = neg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_start) begin
               func_in   = job.func;
               cursor_in = job.cursor;
               chr_in    = job.chr;
               neg_in    = job.neg;
               dig_in    = job.dig;
               cnt_in    = job.cnt;
               idx_in    = '0;
            end
         end
         ST_INIT, ST_LABEL: begin
            if (emit) idx_in = idx_ff + 3'd1;
         end
         ST_WAIT: begin
            if (bcd.done) begin
               dig_in = bcd.digits;
               cnt_in = COUNT_W'(BCD_DIGITS);
            end
         end
         ST_SKIP: begin
            // Leading zeros are dropped one digit a cycle.
            if (skip_zero) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIGIT: begin
            if (emit) begin
               dig_in = {dig_ff[DIG_W-5:0], 4'd0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_BITS: begin
            if (emit) begin
               dig_in = {dig_ff[DIG_W-2:0], 1'b0};
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SPACE: begin
            if (emit) cnt_in = cnt_ff - 1'b1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Output word register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_rs_in    = out_rs_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_rs_in    = emit_rs;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      dig_ff      <= dig_in;
      cursor_ff   <= cursor_in;
      chr_ff      <= chr_in;
      neg_ff      <= neg_in;
      out_rs_ff   <= out_rs_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.is_data  = out_rs_ff;
   assign rsp_ch.bus_byte = out_byte_ff;
   assign rsp_ch.last     = out_last_ff;

endmodule
`default_nettype wire

// ===== sv/char_lcd_number_formatter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD number formatter
// Turns one display request into the sequence of LCD bus writes for it.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request word (func, line, column, value, count); it is
//   taken when valid and ready are both high. ready is high only while no
//   request is in progress, so one request is handled at a time.
//   rsp_ch carries one LCD write per word (is_data, bus_byte, last); last
//   marks the final write of a request. Code 7 is taken and produces nothing.
//   The request is taken into the sequencer registers, and each write is
//   then registered in the output word register. Writes follow one per
//   cycle while the receiver keeps ready high, except while a decimal or
//   hex request prepares its digits. Decimal requests wait for the bit-serial
//   BCD converter, which starts when the request is taken, and then drop
//   leading zeros one digit a cycle. A hex request drops its leading zeros
//   the same way.
//   When the receiver stalls the current write is held in the output
//   register and the sequencer waits; nothing is lost. Synchronous reset
//   empties the output register and returns the block to idle.
// ----------------------------------------------------------------------------
module char_lcd_number_formatter #(
   parameter int MAX_CLEAR = clcd_pkg::MAX_CLEAR_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   clcd_req_if.sink    req_ch,
   clcd_rsp_if.source  rsp_ch
);
   import clcd_pkg::*;

   localparam logic [COUNT_W-1:0] CLEAR_LIM = COUNT_W'(MAX_CLEAR);

   logic               idle;
   logic               accept;
   logic               job_start;
   logic               bcd_start;
   job_type            job;
   bcd_result_type     bcd;
   logic [15:0]        low16;
   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] mag;
   logic [BYTE_W-1:0]  base;
   logic [BYTE_W-1:0]  bin_sat;

   assign req_ch.ready = idle;
   assign accept       = req_ch.valid && idle;
   assign job_start    = accept && (req_ch.func != FUNC_NONE);
   assign bcd_start    = accept &&
                         ((req_ch.func == FUNC_DEC_S) || (req_ch.func == FUNC_DEC_U));

   assign raw     = req_ch.value;
   assign low16   = raw[15:0];
   assign base    = (req_ch.line == 2'd1) ? BASE_LINE1 : BASE_LINE2;
   assign bin_sat = (|low16[15:8]) ? BIN_SAT : low16[7:0];
   // A negative signed request prints the 17-bit magnitude, 65536 included.
   assign mag     = job.neg ? (~raw + VALUE_W'(1)) : {1'b0, low16};

   always_comb begin
      job.func   = req_ch.func;
      job.cursor = base + {2'd0, req_ch.column} - 8'd1;
      job.chr    = raw[7:0];
      job.neg    = (req_ch.func == FUNC_DEC_S) && raw[VALUE_W-1];
      job.dig    = '0;
      job.cnt    = '0;
      priority if (req_ch.func == FUNC_BIN) begin
         job.dig = {bin_sat, 12'd0};
         job.cnt = COUNT_W'(8);
      end else if (req_ch.func == FUNC_HEX) begin
         job.dig = {low16, 4'd0};
         job.cnt = COUNT_W'(4);
      end else if (req_ch.func == FUNC_CLEAR) begin
         job.cnt = (req_ch.count > CLEAR_LIM) ? CLEAR_LIM : req_ch.count;
      end else begin
         job.cnt = '0;
      end
   end

   clcd_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .mag   (mag),
      .res   (bcd)
   );

   clcd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .job_start (job_start),
      .job       (job),
      .bcd       (bcd),
      .idle      (idle),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

// ===== sv/clcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Character LCD number formatter: port checker
// Watches the request and write channels of the top level.
// ----------------------------------------------------------------------------
module clcd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [clcd_pkg::FUNC_W-1:0]  req_func,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [clcd_pkg::BYTE_W-1:0]  rsp_bus_byte,
   input logic                         rsp_is_data,
   input logic                         rsp_last
);
   import clcd_pkg::*;

   // A stalled word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_bus_byte) && $stable(rsp_is_data) && $stable(rsp_last))
      else $error("write word changed while stalled");

   // While a word that is not the last one is offered, the request is still in progress.
   a_busy_mid_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("new request accepted before the previous one finished");

   // An init request keeps the block busy; an unused code leaves it idle.
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_INIT) |=> !req_ready)
      else $error("init request did not start a sequence");

   a_unused_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_NONE) |=> req_ready)
      else $error("unused request code started a sequence");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind char_lcd_number_formatter clcd_checker u_clcd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_func     (req_ch.func),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_bus_byte (rsp_ch.bus_byte),
   .rsp_is_data  (rsp_ch.is_data),
   .rsp_last     (rsp_ch.last)
);
`default_nettype wire
